// ----- rtl/hmmu_pkg.sv -----
// ----------------------------------------------------------------------------
// Handheld memory map unit package
// Shared codes, command queue entry and sizing constants.
// ----------------------------------------------------------------------------
package hmmu_pkg;

  localparam int CART_BANKS_DEF = 128;
  localparam int BANK_SIZE      = 16384;
  localparam int IMAGE_BANKS    = 128;
  localparam int DMA_LEN        = 160;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] CMD_READ      = 2'd0;
  localparam logic [1:0] CMD_WRITE     = 2'd1;
  localparam logic [1:0] CMD_BOOT_LOAD = 2'd2;
  localparam logic [1:0] CMD_CART_LOAD = 2'd3;

  localparam logic [15:0] IO_JOYP     = 16'hFF00;
  localparam logic [15:0] IO_SC       = 16'hFF02;
  localparam logic [15:0] IO_DIV      = 16'hFF04;
  localparam logic [15:0] IO_STAT     = 16'hFF41;
  localparam logic [15:0] IO_DMA      = 16'hFF46;
  localparam logic [15:0] IO_BOOT_OFF = 16'hFF50;
  localparam logic [15:0] OAM_BASE    = 16'hFE00;
  localparam logic [7:0]  SC_START    = 8'h81;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_STORE,
    OP_BANK,
    OP_DMA,
    OP_UNMAP,
    OP_BOOT,
    OP_CART
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [20:0] iaddr;
    logic [7:0]  wdata;
    logic        vram;
    logic        joy;
    logic        ser;
  } entry_t;

endpackage

// ----- rtl/hmmu_if.sv -----
// ----------------------------------------------------------------------------
// Handheld memory map unit channels
// Request and response word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hmmu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [20:0] image_address;
  logic [7:0]  data;

  modport source (output valid, cmd, address, image_address, data, input ready);
  modport sink (input valid, cmd, address, image_address, data, output ready);
endinterface

interface hmmu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       joypad_update;
  logic       serial_start;

  modport source (output valid, read_data, joypad_update, serial_start, input ready);
  modport sink (input valid, read_data, joypad_update, serial_start, output ready);
endinterface

// ----- rtl/handheld_memory_map_unit_top.sv -----
// A CPU read passes from the queue through the back end's idle, read and response states;
// writes and loads go from idle straight to response. The back end takes one operation at a time.
// OAM DMA write: 160 bytes through the single main-store port, each byte read in S_DMA_RD
// and written in S_DMA_WR, before the response word is loaded in S_RESP.
// Reset: rst clears control state, then a sweep over all 65536 addresses zeroes the main store;
// req.ready stays low during the sweep.
// ----------------------------------------------------------------------------
// Handheld memory map unit top level
// Front end classifier, command queue and back-end executor.
// ----------------------------------------------------------------------------
module handheld_memory_map_unit_top
  import hmmu_pkg::*;
#(
  parameter int CART_BANKS = CART_BANKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hmmu_req_if.sink   req,
  hmmu_rsp_if.source rsp
);

  logic   clearing;
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  hmmu_front u_front (
    .clearing   (clearing),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  hmmu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  hmmu_back #(
    .CART_BANKS (CART_BANKS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_entry  (pop_entry),
    .rsp      (rsp)
  );

endmodule

// ----- rtl/hmmu_front.sv -----
// ----------------------------------------------------------------------------
// Handheld memory map unit front end
// Accepts request words and classifies them into back-end operations.
// ----------------------------------------------------------------------------
module hmmu_front
  import hmmu_pkg::*;
(
  input  logic    clearing,
  hmmu_req_if.sink req,
  output logic    push_valid,
  input  logic    push_ready,
  output entry_t  push_entry
);

  assign req.ready  = push_ready & ~clearing;
  assign push_valid = req.valid & ~clearing;

  always_comb begin
    push_entry       = '0;
    push_entry.op    = OP_NONE;
    push_entry.addr  = req.address;
    push_entry.iaddr = req.image_address;
    push_entry.wdata = req.data;
    case (req.cmd)
      CMD_READ: begin
        push_entry.op = OP_READ;
      end
      CMD_WRITE: begin
        if (req.address inside {[16'h2000:16'h3FFF]}) begin
          push_entry.op = OP_BANK;
        end else if (req.address == IO_DMA) begin
          push_entry.op = OP_DMA;
        end else if (req.address == IO_BOOT_OFF) begin
          push_entry.op = OP_UNMAP;
        end else begin
          push_entry.op   = OP_STORE;
          push_entry.vram = req.address inside {[16'h8000:16'h9FFF]};
          if (req.address == IO_JOYP) begin
            push_entry.wdata = req.data & 8'hF0;
            push_entry.joy   = 1'b1;
          end
          if (req.address == IO_SC) begin
            push_entry.ser = (req.data == SC_START);
          end
          if (req.address == IO_DIV) begin
            push_entry.wdata = 8'h00;
          end
        end
      end
      CMD_BOOT_LOAD: begin
        push_entry.op = (req.address <= 16'h00FF) ? OP_BOOT : OP_NONE;
      end
      default: begin
        push_entry.op = OP_CART;
      end
    endcase
  end

endmodule

// ----- rtl/hmmu_queue.sv -----
// ----------------------------------------------------------------------------
// Handheld memory map unit command queue
// Short queue between front end and back end.
// ----------------------------------------------------------------------------
module hmmu_queue
  import hmmu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/hmmu_back.sv -----
// ----------------------------------------------------------------------------
// Handheld memory map unit back end
// Executes queued operations over the main store, boot and cartridge images.
// ----------------------------------------------------------------------------
module hmmu_back
  import hmmu_pkg::*;
#(
  parameter int CART_BANKS = CART_BANKS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  output logic   clearing,
  input  logic   q_valid,
  output logic   q_ready,
  input  entry_t q_entry,
  hmmu_rsp_if.source rsp
);

  localparam int CART_EFF   = (CART_BANKS < IMAGE_BANKS) ? CART_BANKS : IMAGE_BANKS;
  localparam int CART_DEPTH = CART_EFF * BANK_SIZE;
  localparam int CART_AW    = $clog2(CART_DEPTH);
  localparam int OFF_W      = $clog2(BANK_SIZE);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DMA_RD = 3'd3;
  localparam logic [2:0] S_DMA_WR = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  typedef enum logic [1:0] {REG_LOW, REG_BANK, REG_ECHO, REG_MAIN} region_t;
  typedef enum logic [1:0] {SEL_BOOT, SEL_CART, SEL_FF, SEL_MAIN} sel_t;

  function automatic region_t map_region(input logic [15:0] a);
    region_t r;
    r = REG_MAIN;
    if (a <= 16'h00FF) begin
      r = REG_LOW;
    end else if (a inside {[16'h4000:16'h7FFF]}) begin
      r = REG_BANK;
    end else if (a inside {[16'hE000:16'hFDFF]}) begin
      r = REG_ECHO;
    end
    return r;
  endfunction

  function automatic sel_t read_sel(input region_t r, input logic mapped, input logic bank_ok);
    sel_t s;
    case (r)
      REG_LOW:  s = mapped ? SEL_BOOT : SEL_MAIN;
      REG_BANK: s = bank_ok ? SEL_CART : SEL_FF;
      default:  s = SEL_MAIN;
    endcase
    return s;
  endfunction

  logic [7:0]          main_mem [65536];
  logic [7:0]          boot_mem [256];
  logic [7:0]          cart_mem [CART_DEPTH];

  logic [2:0]          state;
  logic [15:0]         clr_cnt;
  logic                boot_mapped;
  logic [7:0]          bank;
  logic                vram_lock;
  logic [7:0]          dma_base;
  logic [7:0]          dma_cnt;
  sel_t                rd_sel;
  logic                out_valid;
  logic [7:0]          res_data;
  logic                res_joy;
  logic                res_ser;
  logic [7:0]          out_data;
  logic                out_joy;
  logic                out_ser;

  logic                q_pop;
  logic                bank_ok;
  logic [15:0]         rd_addr;
  region_t             rd_region;
  logic [15:0]         main_raddr;
  logic [21:0]         cart_full;
  logic [CART_AW-1:0]  cart_raddr;
  logic                cart_fits;
  logic                boot_we;
  logic                cart_we;
  logic                mem_we;
  logic [15:0]         mem_waddr;
  logic [7:0]          mem_wdata;
  logic [7:0]          main_rdata;
  logic [7:0]          boot_rdata;
  logic [7:0]          cart_rdata;
  logic [7:0]          map_data;
  logic                out_free;

  assign clearing   = (state == S_CLEAR);
  assign q_ready    = (state == S_IDLE);
  assign q_pop      = q_ready & q_valid;
  assign bank_ok    = ({1'b0, bank} < 9'(CART_EFF));
  assign rd_addr    = (state == S_DMA_RD) ? {dma_base, dma_cnt} : q_entry.addr;
  assign rd_region  = map_region(rd_addr);
  assign main_raddr = (rd_region == REG_ECHO) ? rd_addr - 16'h2000 : rd_addr;
  assign cart_full  = {bank, rd_addr[OFF_W-1:0]};
  assign cart_raddr = cart_full[CART_AW-1:0];
  assign cart_fits  = ({1'b0, q_entry.iaddr} < 22'(CART_DEPTH));
  assign boot_we    = q_pop && (q_entry.op == OP_BOOT);
  assign cart_we    = q_pop && (q_entry.op == OP_CART) && cart_fits;
  assign out_free   = ~out_valid | rsp.ready;

  always_comb begin
    case (rd_sel)
      SEL_BOOT: map_data = boot_rdata;
      SEL_CART: map_data = cart_rdata;
      SEL_FF:   map_data = 8'hFF;
      default:  map_data = main_rdata;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = q_entry.addr;
    mem_wdata = q_entry.wdata;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = 8'h00;
      end
      S_IDLE: begin
        if (q_valid && q_entry.op == OP_STORE) begin
          mem_we = ~(q_entry.vram & vram_lock);
        end else if (q_valid && q_entry.op == OP_CART) begin
          mem_we    = (q_entry.iaddr < 21'h008000);
          mem_waddr = q_entry.iaddr[15:0];
        end
      end
      S_DMA_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {OAM_BASE[15:8], dma_cnt};
        mem_wdata = map_data;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      main_mem[mem_waddr] <= mem_wdata;
    end
    main_rdata <= main_mem[main_raddr];
  end

  always_ff @(posedge clk) begin
    if (boot_we) begin
      boot_mem[q_entry.addr[7:0]] <= q_entry.wdata;
    end
    boot_rdata <= boot_mem[rd_addr[7:0]];
  end

  always_ff @(posedge clk) begin
    if (cart_we) begin
      cart_mem[q_entry.iaddr[CART_AW-1:0]] <= q_entry.wdata;
    end
    cart_rdata <= cart_mem[cart_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      boot_mapped <= 1'b1;
      bank        <= 8'd1;
      vram_lock   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (rsp.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == 16'hFFFF) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            res_data <= 8'h00;
            res_joy  <= q_entry.joy;
            res_ser  <= q_entry.ser;
            case (q_entry.op)
              OP_READ: begin
                rd_sel <= read_sel(rd_region, boot_mapped, bank_ok);
                state  <= S_READ;
              end
              OP_STORE: begin
                if (q_entry.addr == IO_STAT) begin
                  vram_lock <= (q_entry.wdata[1:0] == 2'b11);
                end
                state <= S_RESP;
              end
              OP_BANK: begin
                bank  <= (q_entry.wdata == 8'h00) ? 8'd1 : q_entry.wdata;
                state <= S_RESP;
              end
              OP_DMA: begin
                dma_base <= q_entry.wdata;
                dma_cnt  <= 8'd0;
                state    <= S_DMA_RD;
              end
              OP_UNMAP: begin
                boot_mapped <= 1'b0;
                state       <= S_RESP;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_READ: begin
          res_data <= map_data;
          state    <= S_RESP;
        end
        S_DMA_RD: begin
          rd_sel <= read_sel(rd_region, boot_mapped, bank_ok);
          state  <= S_DMA_WR;
        end
        S_DMA_WR: begin
          if (dma_cnt == 8'(DMA_LEN - 1)) begin
            state <= S_RESP;
          end else begin
            dma_cnt <= dma_cnt + 1'b1;
            state   <= S_DMA_RD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res_data;
            out_joy   <= res_joy;
            out_ser   <= res_ser;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = out_data;
  assign rsp.joypad_update = out_joy;
  assign rsp.serial_start  = out_ser;

  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !q_pop)
    else $error("queue popped during clear sweep");

  a_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    bank != 8'd0)
    else $error("selected bank is zero");

  a_dma_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_DMA_WR) |-> (mem_waddr[15:8] == OAM_BASE[15:8]) && (dma_cnt < 8'(DMA_LEN)))
    else $error("dma write outside object table");

  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RESP))
    else $error("response word loaded outside response state");

  a_boot_unmap_sticky: assert property (@(posedge clk) disable iff (rst)
    !$rose(boot_mapped))
    else $error("boot image remapped");

endmodule

// ----- tb/sv/handheld_memory_map_unit_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Handheld memory map unit testbench
// Drives CPU reads, writes and image loads through the request channel and
// checks every response word against an in-order model of the memory map:
// boot overlay, switched cartridge bank, echo fold, VRAM lock, joypad,
// serial, divider, OAM DMA and boot unmap. Both channels idle at random.
// ----------------------------------------------------------------------------
module handheld_memory_map_unit_top_tb
  import hmmu_pkg::*;
();

  localparam int CART_BANKS = CART_BANKS_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [20:0] image_address;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       joypad_update;
    logic       serial_start;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  hmmu_req_if req_ch ();
  hmmu_rsp_if rsp_ch ();

  handheld_memory_map_unit_top #(
    .CART_BANKS(CART_BANKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #10 clk = ~clk;

  // memory map model
  logic [7:0] main_mem [0:65535];
  logic [7:0] boot_rom [0:255];
  logic [7:0] cart_rom [int];
  bit         boot_on;
  logic [7:0] rom_bank;

  // stimulus-side view of what may be read
  bit         boot_known [0:255];
  bit         cart_known [int];
  bit         gen_boot_on;
  logic [7:0] gen_bank;
  logic [15:0] recent_writes [$];

  access_t pending_words [$];
  result_t expected_results [$];
  int unsigned words_total;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cycle_count;
  int idle_left;
  int stall_left;
  bit req_burst;
  bit rsp_burst;

  function automatic logic [7:0] fetch_byte(logic [15:0] a);
    int idx;
    if (boot_on && a <= 16'h00FF) return boot_rom[a[7:0]];
    if (a >= 16'h4000 && a <= 16'h7FFF) begin
      if (rom_bank >= CART_BANKS || rom_bank >= IMAGE_BANKS) return 8'hFF;
      idx = rom_bank * BANK_SIZE + (a - 16'h4000);
      return cart_rom.exists(idx) ? cart_rom[idx] : 8'h00;
    end
    if (a >= 16'hE000 && a <= 16'hFDFF) return main_mem[a - 16'h2000];
    return main_mem[a];
  endfunction

  function automatic void store_byte(input logic [15:0] a, input logic [7:0] d,
                                     inout result_t r);
    int i;
    if (a >= 16'h2000 && a <= 16'h3FFF) begin
      rom_bank = (d == 8'h00) ? 8'h01 : d;
      return;
    end
    if (a >= 16'h8000 && a <= 16'h9FFF && main_mem[IO_STAT][1:0] == 2'b11) return;
    case (a)
      IO_JOYP: begin
        main_mem[a] = {d[7:4], main_mem[a][3:0]};
        r.joypad_update = 1'b1;
      end
      IO_SC: begin
        r.serial_start = (d == SC_START);
        main_mem[a] = d;
      end
      IO_DIV: main_mem[a] = 8'h00;
      IO_DMA: begin
        for (i = 0; i < DMA_LEN; i++)
          main_mem[OAM_BASE + i] = fetch_byte({d, 8'h00} + i[15:0]);
      end
      IO_BOOT_OFF: boot_on = 1'b0;
      default: main_mem[a] = d;
    endcase
  endfunction

  function automatic result_t apply_access(logic [1:0] cmd, logic [15:0] a,
                                           logic [20:0] ia, logic [7:0] d);
    result_t r;
    r = '0;
    case (cmd)
      CMD_READ: r.read_data = fetch_byte(a);
      CMD_WRITE: store_byte(a, d, r);
      CMD_BOOT_LOAD: if (a <= 16'h00FF) boot_rom[a[7:0]] = d;
      default: begin
        cart_rom[int'(ia)] = d;
        if (ia < 21'h008000) main_mem[ia[15:0]] = d;
      end
    endcase
    return r;
  endfunction

  function automatic bit read_safe(logic [15:0] a);
    if (gen_boot_on && a <= 16'h00FF) return boot_known[a[7:0]];
    if (a >= 16'h4000 && a <= 16'h7FFF && gen_bank < CART_BANKS && gen_bank < IMAGE_BANKS)
      return cart_known.exists(gen_bank * BANK_SIZE + (a - 16'h4000));
    return 1'b1;
  endfunction

  function automatic bit page_safe(logic [7:0] page);
    int i;
    for (i = 0; i < DMA_LEN; i++)
      if (!read_safe({page, 8'h00} + i[15:0])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_item(logic [1:0] cmd, logic [15:0] a, logic [20:0] ia, logic [7:0] d);
    access_t w;
    w.cmd = cmd;
    w.address = a;
    w.image_address = ia;
    w.data = d;
    case (cmd)
      CMD_WRITE: begin
        if (a >= 16'h2000 && a <= 16'h3FFF) gen_bank = (d == 8'h00) ? 8'h01 : d;
        if (a == IO_BOOT_OFF) gen_boot_on = 1'b0;
        recent_writes.insert(recent_writes.size(), a);
        if (recent_writes.size() > 32) void'(recent_writes.pop_front());
      end
      CMD_BOOT_LOAD: if (a <= 16'h00FF) boot_known[a[7:0]] = 1'b1;
      CMD_CART_LOAD: cart_known[int'(ia)] = 1'b1;
      default: ;
    endcase
    pending_words.insert(pending_words.size(), w);
  endtask

  // load the image byte behind a read first, if it was never loaded
  task automatic preload(logic [15:0] a);
    if (read_safe(a)) return;
    if (a <= 16'h00FF)
      push_item(CMD_BOOT_LOAD, a, 21'($urandom_range(0, 21'h1FFFFF)),
                8'($urandom_range(0, 255)));
    else
      push_item(CMD_CART_LOAD, 16'($urandom_range(0, 65535)),
                21'(gen_bank * BANK_SIZE + (a - 16'h4000)), 8'($urandom_range(0, 255)));
  endtask

  task automatic push_read(logic [15:0] a);
    preload(a);
    push_item(CMD_READ, a, 21'($urandom_range(0, 21'h1FFFFF)), 8'($urandom_range(0, 255)));
  endtask

  task automatic push_write(logic [15:0] a, logic [7:0] d);
    push_item(CMD_WRITE, a, 21'($urandom_range(0, 21'h1FFFFF)), d);
  endtask

  task automatic random_read();
    logic [15:0] a;
    if (recent_writes.size() > 0 && $urandom_range(0, 2) == 0)
      a = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
    else begin
      case ($urandom_range(0, 6))
        0: a = 16'($urandom_range(16'h0000, 16'h00FF));
        1: a = 16'($urandom_range(16'h4000, 16'h7FFF));
        2: a = 16'($urandom_range(16'hE000, 16'hFDFF));
        3: a = 16'($urandom_range(16'hFE00, 16'hFE9F));
        4: a = 16'($urandom_range(16'hFF00, 16'hFF7F));
        5: a = 16'($urandom_range(16'h8000, 16'h9FFF));
        default: a = 16'($urandom_range(0, 65535));
      endcase
    end
    push_read(a);
  endtask

  task automatic random_write(bit allow_unmap);
    int i;
    int r;
    logic [15:0] a;
    logic [7:0] d;
    r = $urandom_range(0, 13);
    d = 8'($urandom_range(0, 255));
    case (r)
      0: begin
        a = 16'($urandom_range(16'h2000, 16'h3FFF));
        if ($urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 7));
      end
      1: a = 16'($urandom_range(16'h8000, 16'h9FFF));
      2: a = IO_JOYP;
      3: begin
        a = IO_SC;
        if ($urandom_range(0, 1) == 1) d = SC_START;
      end
      4: a = IO_DIV;
      5: a = IO_STAT;
      6: begin
        a = IO_DMA;
        if (recent_writes.size() > 0 && $urandom_range(0, 1) == 1)
          d = recent_writes[$urandom_range(0, recent_writes.size() - 1)][15:8];
      end
      7: a = 16'($urandom_range(16'hE000, 16'hFDFF));
      8: a = 16'($urandom_range(16'hFF80, 16'hFFFF));
      9, 10: a = 16'($urandom_range(16'hC000, 16'hDFFF));
      11: a = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16'h0000, 16'h1FFF))
                                          : 16'($urandom_range(16'h4000, 16'h7FFF));
      default: a = 16'($urandom_range(0, 65535));
    endcase
    if (a == IO_BOOT_OFF && !allow_unmap) a = IO_BOOT_OFF + 16'd1;
    if (a == IO_DMA && !page_safe(d)) begin
      if ($urandom_range(0, 19) == 0) begin
        for (i = 0; i < DMA_LEN; i++) preload({d, 8'h00} + i[15:0]);
      end else begin
        do d = 8'($urandom_range(0, 255)); while (!page_safe(d));
      end
    end
    push_write(a, d);
  endtask

  task automatic random_phase(int n, bit allow_unmap);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) random_read();
      else if (sel < 80) random_write(allow_unmap);
      else if (sel < 88)
        push_item(CMD_BOOT_LOAD,
                  ($urandom_range(0, 9) == 0) ? 16'($urandom_range(16'h0100, 16'hFFFF))
                                              : 16'($urandom_range(0, 255)),
                  21'($urandom_range(0, 21'h1FFFFF)), 8'($urandom_range(0, 255)));
      else
        push_item(CMD_CART_LOAD, 16'($urandom_range(0, 65535)),
                  ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 21'h007FFF))
                                              : 21'($urandom_range(0, 21'h1FFFFF)),
                  8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_READ;
    req_ch.address = '0;
    req_ch.image_address = '0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    for (i = 0; i < 65536; i++) main_mem[i] = 8'h00;
    boot_on = 1'b1;
    rom_bank = 8'h01;
    gen_boot_on = 1'b1;
    gen_bank = 8'h01;

    push_item(CMD_BOOT_LOAD, 16'h0000, 21'h1FFFFF, 8'hA5);
    push_item(CMD_BOOT_LOAD, 16'h00FF, 21'h000000, 8'h5A);
    push_item(CMD_BOOT_LOAD, 16'hFFFF, 21'h000000, 8'h77);
    push_read(16'h0000);
    push_read(16'h00FF);
    push_item(CMD_CART_LOAD, 16'hFFFF, 21'h000100, 8'h3C);
    push_read(16'h0100);
    push_write(16'h2000, 8'h00);
    push_item(CMD_CART_LOAD, 16'h0000, 21'h004000, 8'h11);
    push_read(16'h4000);
    push_write(16'h3FFF, 8'h7F);
    push_item(CMD_CART_LOAD, 16'h0000, 21'h1FFFFF, 8'hC3);
    push_read(16'h7FFF);
    push_write(16'h2000, 8'hFF);
    push_read(16'h4000);
    push_write(16'hC123, 8'h99);
    push_read(16'hE123);
    push_write(IO_STAT, 8'h03);
    push_write(16'h8000, 8'h55);
    push_read(16'h8000);
    push_write(IO_STAT, 8'h00);
    push_write(IO_JOYP, 8'hFF);
    push_read(IO_JOYP);
    push_write(IO_SC, SC_START);
    push_write(IO_DIV, 8'hFF);
    push_read(IO_DIV);
    push_write(IO_DMA, 8'hC1);
    push_read(16'hFE23);

    random_phase(310, 1'b0);
    // drop the boot image for the second half
    push_write(IO_BOOT_OFF, 8'($urandom_range(0, 255)));
    push_read(16'h0000);
    random_phase(320, 1'b1);
    words_total = pending_words.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (results_checked < words_total) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin : drive_req
    access_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (idle_left > 0) begin
        req_ch.valid <= 1'b0;
        idle_left--;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= w.cmd;
        req_ch.address <= w.address;
        req_ch.image_address <= w.image_address;
        req_ch.data <= w.data;
        if ($urandom_range(0, 49) == 0) req_burst = !req_burst;
        idle_left = req_burst ? 0 : pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_rsp_ready
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!rsp_burst && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      if ($urandom_range(0, 99) == 0) rsp_burst = !rsp_burst;
    end
  end

  always @(posedge clk) begin : track_words
    result_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("response word with nothing outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.read_data !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, rsp_ch.read_data);
            mismatches++;
          end
          if (rsp_ch.joypad_update !== want.joypad_update) begin
            $error("joypad_update: expected %0b, got %0b",
                   want.joypad_update, rsp_ch.joypad_update);
            mismatches++;
          end
          if (rsp_ch.serial_start !== want.serial_start) begin
            $error("serial_start: expected %0b, got %0b",
                   want.serial_start, rsp_ch.serial_start);
            mismatches++;
          end
        end
        results_checked++;
      end
      if (req_ch.valid && req_ch.ready)
        expected_results.insert(expected_results.size(),
                                apply_access(req_ch.cmd, req_ch.address,
                                             req_ch.image_address, req_ch.data));
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/hmmu_pkg.sv
rtl/hmmu_if.sv
rtl/hmmu_front.sv
rtl/hmmu_queue.sv
rtl/hmmu_back.sv
rtl/handheld_memory_map_unit_top.sv
tb/sv/handheld_memory_map_unit_top_tb.sv
